/* design/dges_pkg.sv */
`timescale 1ns / 1ps
// Directed graph edge store: shared types, command and status codes, FSM states.
// No dependencies.
package dges_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_REM  = 3'd1;
  localparam logic [2:0] CMD_TEST = 3'd2;
  localparam logic [2:0] CMD_SUCC = 3'd3;
  localparam logic [2:0] CMD_PRED = 3'd4;
  localparam logic [2:0] CMD_DEG  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NO    = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] source_vertex;
    logic [5:0] target_vertex;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_SCAN
  } state_t;

endpackage

/* design/directed_graph_edge_store.sv */
`timescale 1ns / 1ps
// Directed graph edge store top level: adjacency row memory and command sequencer.
// Depends on dges_pkg.
//
// Usage
//   A command is taken at a clock edge with start high and busy low. in_data holds
//   command, source and target vertex. Results leave on out_data, each valid for
//   exactly one cycle while out_valid is high; the receiver cannot stall them.
//   cfg_we writes vertex_count from cfg_wdata; write it only while the block is idle.
// Command sequence
//   A command with an invalid vertex or an undefined code: result registered at the
//   transfer and valid in the following cycle; next command may follow at once.
//   Add, remove, test: one row read, then the result; add or remove writes the changed
//   row back when the edge bit changes. The next command waits until busy falls.
//   Successors, predecessors, degree: the row of the source, then one row read per
//   active vertex through the single memory read port; list results appear as hits
//   are found, the last marked.
// Reset
//   Synchronous, active low. Each row carries a valid flag cleared at reset, so the
//   matrix reads as empty at once; no clearing pass. vertex_count returns to 64.
module directed_graph_edge_store #(
  parameter int MAX_VERTICES = dges_pkg::MAX_VERTICES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  dges_pkg::in_t          in_data,
  output logic                   busy,
  output logic                   out_valid,
  output dges_pkg::out_t         out_data,
  input  logic                   cfg_we,
  input  logic [dges_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [dges_pkg::CNT_W-1:0] MaxCnt = dges_pkg::CNT_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] OneBit = MAX_VERTICES'(1);

  dges_pkg::state_t state_r, state_nxt;

  logic [dges_pkg::CNT_W-1:0] vcount_r;

  logic [2:0]              cmd_r, cmd_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [AW-1:0]           tgt_r, tgt_nxt;
  logic                    tgt_ok_r, tgt_ok_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    pv_r, pv_nxt;
  logic [AW-1:0]           pidx_r, pidx_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           pend_idx_r, pend_idx_nxt;
  logic [7:0]              deg_r, deg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  dges_pkg::out_t          out_r, out_nxt;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mem_q;
  logic                    rvld_q;
  logic [MAX_VERTICES-1:0] row_valid_r;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [MAX_VERTICES-1:0] wr_row;

  logic [dges_pkg::CNT_W-1:0] n_w;
  logic                    src_ok;
  logic                    tgt_ok;
  logic [MAX_VERTICES-1:0] cur_row;
  logic                    cur_bit;
  logic                    hit_succ;
  logic                    hit_pred;
  logic                    issue;

  assign n_w      = (vcount_r > MaxCnt) ? MaxCnt : vcount_r;
  assign src_ok   = {1'b0, in_data.source_vertex} < n_w;
  assign tgt_ok   = {1'b0, in_data.target_vertex} < n_w;
  assign cur_row  = rvld_q ? mem_q : '0;
  assign cur_bit  = cur_row[tgt_r];
  assign hit_succ = row_r[pidx_r];
  assign hit_pred = cur_row[src_r];
  assign issue    = idx_r < n_r;

  // row store: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[src_r] <= wr_row;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvld_q      <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[src_r] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= row_valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= dges_pkg::VERTEX_COUNT_RST;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dges_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    src_r      <= src_nxt;
    tgt_r      <= tgt_nxt;
    tgt_ok_r   <= tgt_ok_nxt;
    n_r        <= n_nxt;
    row_r      <= row_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    pend_idx_r <= pend_idx_nxt;
    deg_r      <= deg_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    logic bad;
    logic hit;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    src_nxt       = src_r;
    tgt_nxt       = tgt_r;
    tgt_ok_nxt    = tgt_ok_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    deg_nxt       = deg_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = src_r;
    wr_en         = 1'b0;
    wr_row        = cur_row;
    bad           = 1'b0;
    hit           = 1'b0;

    case (state_r)
      dges_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_data.command;
          src_nxt    = in_data.source_vertex[AW-1:0];
          tgt_nxt    = in_data.target_vertex[AW-1:0];
          tgt_ok_nxt = tgt_ok;
          n_nxt      = n_w[CW-1:0];
          case (in_data.command)
            dges_pkg::CMD_ADD, dges_pkg::CMD_REM: bad = !src_ok || !tgt_ok;
            dges_pkg::CMD_TEST, dges_pkg::CMD_SUCC,
            dges_pkg::CMD_PRED, dges_pkg::CMD_DEG: bad = !src_ok;
            default: bad = 1'b1;
          endcase
          if (bad) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: dges_pkg::ST_BAD, value: 8'd0, last: 1'b1};
          end else begin
            rd_en     = 1'b1;
            rd_addr   = in_data.source_vertex[AW-1:0];
            state_nxt = dges_pkg::S_ROW;
          end
        end
      end

      dges_pkg::S_ROW: begin
        case (cmd_r)
          dges_pkg::CMD_ADD: begin
            out_valid_nxt = 1'b1;
            state_nxt     = dges_pkg::S_IDLE;
            if (cur_bit) begin
              out_nxt = '{status: dges_pkg::ST_NO, value: 8'd0, last: 1'b1};
            end else begin
              wr_en   = 1'b1;
              wr_row  = cur_row | (OneBit << tgt_r);
              out_nxt = '{status: dges_pkg::ST_OK, value: 8'd0, last: 1'b1};
            end
          end
          dges_pkg::CMD_REM: begin
            out_valid_nxt = 1'b1;
            state_nxt     = dges_pkg::S_IDLE;
            if (cur_bit) begin
              wr_en   = 1'b1;
              wr_row  = cur_row & ~(OneBit << tgt_r);
              out_nxt = '{status: dges_pkg::ST_OK, value: 8'd0, last: 1'b1};
            end else begin
              out_nxt = '{status: dges_pkg::ST_NO, value: 8'd0, last: 1'b1};
            end
          end
          dges_pkg::CMD_TEST: begin
            out_valid_nxt = 1'b1;
            state_nxt     = dges_pkg::S_IDLE;
            if (tgt_ok_r && cur_bit) begin
              out_nxt = '{status: dges_pkg::ST_OK, value: 8'd0, last: 1'b1};
            end else begin
              out_nxt = '{status: dges_pkg::ST_NO, value: 8'd0, last: 1'b1};
            end
          end
          default: begin
            row_nxt   = cur_row;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            deg_nxt   = 8'd0;
            state_nxt = dges_pkg::S_SCAN;
          end
        endcase
      end

      dges_pkg::S_SCAN: begin
        // issue row idx_r, evaluate row pidx_r returned from the previous read
        if (issue) begin
          rd_en    = 1'b1;
          rd_addr  = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end
        if (pv_r) begin
          case (cmd_r)
            dges_pkg::CMD_SUCC: hit = hit_succ;
            dges_pkg::CMD_PRED: hit = hit_pred;
            default: hit = 1'b0;
          endcase
          if (cmd_r == dges_pkg::CMD_DEG) begin
            deg_nxt = deg_r + 8'(hit_succ) + 8'(hit_pred);
          end
          if (hit) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: dges_pkg::ST_OK, value: 8'(pend_idx_r), last: 1'b0};
            end
            pend_nxt     = 1'b1;
            pend_idx_nxt = pidx_r;
          end
        end
        if (!issue && !pv_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = dges_pkg::S_IDLE;
          if (cmd_r == dges_pkg::CMD_DEG) begin
            out_nxt = '{status: dges_pkg::ST_OK, value: deg_r, last: 1'b1};
          end else if (pend_r) begin
            out_nxt = '{status: dges_pkg::ST_OK, value: 8'(pend_idx_r), last: 1'b1};
          end else begin
            out_nxt = '{status: dges_pkg::ST_EMPTY, value: 8'd0, last: 1'b1};
          end
        end
      end

      default: begin
        state_nxt = dges_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != dges_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/dges_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the directed graph edge store, bound to the top level.
// Depends on dges_pkg and directed_graph_edge_store.
module dges_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input dges_pkg::out_t out_data
);

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // an accepted command either answers at once or holds the block busy
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || (out_valid && out_data.last)))
    else $error("accepted command neither answered nor in progress");

  // further results of a list still to come: block must stay busy
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> busy)
    else $error("non-final result while idle");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == dges_pkg::ST_EMPTY) |->
      (out_data.last && out_data.value == 8'd0))
    else $error("empty list result malformed");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == dges_pkg::ST_BAD) |->
      (out_data.last && out_data.value == 8'd0))
    else $error("invalid result malformed");

endmodule

bind directed_graph_edge_store dges_checker u_dges_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
